### hw/rtl/qadr_pkg.sv
// qadr_pkg: widths, constants, codes and shared functions of the attitude and
// dead-reckoning core. No dependencies; every file under hw/rtl imports it.
package qadr_pkg;

	localparam int STATE_WIDTH  = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int CIW          = $clog2(CORDIC_STEPS);

	localparam int DW    = 16;   // input sample fields
	localparam int TSW   = 32;   // timestamp, step time
	localparam int AW    = 34;   // Q2.30 rotation terms, doubled
	localparam int MAW   = 35;   // matrix terms before rounding
	localparam int MW    = 21;   // Q16.16 gravity and matrix entries
	localparam int LINW  = 22;   // Q16.16 linear acceleration
	localparam int CW    = 37;   // CORDIC x/y
	localparam int ZW    = 34;   // CORDIC angle, Q29
	localparam int ANGW  = 20;   // Q3.13 angle results
	localparam int OPW   = (STATE_WIDTH > AW ? STATE_WIDTH : AW) + 2;
	localparam int PRODW = OPW + TSW;
	localparam int QW    = PRODW - 19;
	localparam int DVW   = QW + 1;
	localparam int SATW  = DVW + 2;
	localparam int DCW   = $clog2(PRODW + 1);
	localparam int SQW   = 61;   // isqrt radicand
	localparam int RTW   = 31;   // isqrt root

	// divide by 10^6, one 12-bit quotient digit at a time
	localparam int DCH   = 12;
	localparam int NCH   = 6;
	localparam int DIVW  = DCH * NCH;
	localparam int RCPSH = 52;
	// 2^52 / 10^6 rounded up; exact for 32-bit partial dividends
	localparam logic [32:0] RCP = 33'd4503599628;

	localparam logic [19:0]           USEC       = 20'd1000000;
	localparam logic signed [ZW-1:0]  PI_Q29     = 34'sd1686629713;
	localparam logic signed [ANGW-1:0] TWO_PI_Q13 = 20'sd51472;
	localparam logic [SQW-1:0]        ONE_Q60    = 61'h1000000000000000;

	localparam logic signed [ZW-1:0] ATAN_Q29 [24] = '{
		34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762579,
		34'sd33510843,  34'sd16771758,  34'sd8387925,   34'sd4194219,
		34'sd2097141,   34'sd1048575,   34'sd524288,    34'sd262144,
		34'sd131072,    34'sd65536,     34'sd32768,     34'sd16384,
		34'sd8192,      34'sd4096,      34'sd2048,      34'sd1024,
		34'sd512,       34'sd256,       34'sd128,       34'sd64
	};

	localparam logic       REG_DEAD_BAND = 1'b0;
	localparam logic       REG_DECL      = 1'b1;
	localparam logic       CMD_CLEAR     = 1'b1;

	localparam logic [3:0] KIND_ANGLES  = 4'd0;
	localparam logic [3:0] KIND_GRAVITY = 4'd1;
	localparam logic [3:0] KIND_LIN     = 4'd2;
	localparam logic [3:0] KIND_DISP    = 4'd3;
	localparam logic [3:0] KIND_VEL     = 4'd4;
	localparam logic [3:0] KIND_POS     = 4'd5;
	localparam logic [3:0] KIND_ROW0    = 4'd6;
	localparam logic [3:0] KIND_ROW1    = 4'd7;
	localparam logic [3:0] KIND_ROW2    = 4'd8;
	localparam logic [3:0] KIND_QUAL    = 4'd9;

	typedef enum logic [3:0] {
		T_IDLE, T_PROD, T_SUMS, T_LIN, T_SQMUL, T_SQSTART, T_SQRT, T_CORD, T_POST, T_OUT
	} top_st_t;

	typedef enum logic [1:0] {
		LN_IDLE, LN_MUL, LN_DIV
	} lane_st_t;

	typedef struct packed {
		logic                          busy;
		logic signed [STATE_WIDTH-1:0] disp;
		logic signed [STATE_WIDTH-1:0] vel;
		logic signed [STATE_WIDTH-1:0] pos;
	} intg_stat_t;

	function automatic logic signed [STATE_WIDTH-1:0] sat_state(
		input logic signed [SATW-1:0] v);
		logic signed [SATW-1:0] hi;
		logic signed [SATW-1:0] lo;
		hi = SATW'({1'b0, {(STATE_WIDTH-1){1'b1}}});
		lo = -hi - SATW'(1);
		if (v > hi)
			return hi[STATE_WIDTH-1:0];
		else if (v < lo)
			return lo[STATE_WIDTH-1:0];
		else
			return v[STATE_WIDTH-1:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [SATW-1:0] v);
		if (v > SATW'(64'sd2147483647))
			return 32'sh7fffffff;
		else if (v < -SATW'(64'sd2147483648))
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// Q2.30 -> Q16.16, half up
	function automatic logic signed [MW-1:0] rnd14(input logic signed [MAW-1:0] v);
		logic signed [MAW-1:0] t;
		t = (v + MAW'(8192)) >>> 14;
		return t[MW-1:0];
	endfunction

endpackage

### hw/rtl/quaternion_attitude_dead_reckoning_core.sv
// quaternion_attitude_dead_reckoning_core: top level, sample front end, lane
// control and result merging. Depends on qadr_pkg, qadr_cordic, qadr_isqrt, qadr_intg.
//
// Input stream s_*: one beat per fused IMU sample. s_tuser is cmd; a clear
// beat zeroes velocity, position and the quality extremes and sends nothing.
// Output stream m_*: ten beats per sample, kinds 0 to 9 in order in m_tuser,
// m_tlast on the quality beat. cfg_*: register writes, always ready, to be
// issued only while the core is idle.
// The three axis integrators run side by side, each with two serial
// multiply and divide-by-10^6 passes; the square root and the three CORDIC
// lanes overlap with them. Then ten result beats follow, one per cycle when
// m_tready stays high; s_tready is high only between samples. A stalled
// receiver holds the current beat.
// Reset clears the integrators, the timestamp reference, the quality
// extremes and the registers (dead band 0, declination 162).
module quaternion_attitude_dead_reckoning_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// quat_w, quat_x, quat_y, quat_z, accel_x, accel_y, accel_z, timestamp_us
	input  logic [143:0] s_tdata,
	// cmd
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// value_a, value_b, value_c
	output logic [95:0]  m_tdata,
	// kind
	output logic [3:0]   m_tuser,
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import qadr_pkg::*;

	top_st_t st_q, st_n;

	logic [14:0]             band_q;
	logic signed [DW-1:0]    decl_q;
	logic [TSW-1:0]          prev_ts_q, dt_q;
	logic signed [DW-1:0]    w_q, x_q, y_q, z_q, ax_q, ay_q, az_q;
	logic                    s_acc, is_clear;

	logic signed [31:0] ww_s1, xx_s1, yy_s1, zz_s1, wx_s1, wy_s1, wz_s1;
	logic signed [31:0] xy_s1, xz_s1, yz_s1;
	logic signed [AW-1:0] a12_s2, a22_s2, a31_s2, a32_s2, a33_s2;
	logic signed [MW-1:0] m_s2 [9];
	logic signed [31:0]   qual_s2, qmin_q, qmax_q;
	logic signed [MW-1:0] g31_s3, g32_s3, g33_s3;
	logic signed [LINW-1:0] lin_s3 [3];
	logic signed [31:0]   sin_s3;
	logic [RTW-1:0]       mabs_s3;
	logic [2*RTW-1:0]     msq_s4;

	logic signed [AW-1:0]  a12, a22, a31, a32, a33;
	logic signed [MAW-1:0] mfull [9];
	logic signed [35:0]    qsum;
	logic signed [MW-1:0]  g31, g32, g33;
	logic signed [LINW-1:0] lraw [3];
	logic [LINW-1:0]       labs [3];
	logic [LINW-1:0]       bandx;
	logic signed [31:0]    sclamp;

	logic                  sq_start, sq_busy;
	logic [RTW-1:0]        sq_root;
	logic                  cd_start;
	logic [2:0]            cd_busy;
	logic signed [ZW-1:0]  cd_z [3];
	logic signed [CW-1:0]  cd_y [3];
	logic signed [CW-1:0]  cd_x [3];
	logic                  ln_start, lanes_busy;
	intg_stat_t            ln_stat [3];

	logic signed [ANGW-1:0] roll_q, pitch_q, yaw_q;
	logic signed [ANGW-1:0] roll_n, pitch_n, yaw0, yaw1, yaw2, yaw3, yaw4;
	logic [3:0]             beat_q;
	logic signed [31:0]     va, vb, vc;

	assign s_tready  = st_q == T_IDLE;
	assign cfg_ready = 1'b1;
	assign s_acc     = s_tvalid && s_tready;
	assign is_clear  = s_tuser[0] == CMD_CLEAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= '0;
			decl_q <= 16'sd162;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEAD_BAND: band_q <= cfg_data[14:0];
				REG_DECL:      decl_q <= cfg_data;
				default:       band_q <= band_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= T_IDLE;
		else
			st_q <= st_n;
	end

	always_comb begin
		st_n = st_q;
		case (st_q)
			T_IDLE:    if (s_acc && !is_clear) st_n = T_PROD;
			T_PROD:    st_n = T_SUMS;
			T_SUMS:    st_n = T_LIN;
			T_LIN:     st_n = T_SQMUL;
			T_SQMUL:   st_n = T_SQSTART;
			T_SQSTART: st_n = T_SQRT;
			T_SQRT:    if (!sq_busy) st_n = T_CORD;
			T_CORD:    if (cd_busy == '0 && !lanes_busy) st_n = T_POST;
			T_POST:    st_n = T_OUT;
			T_OUT:     if (m_tready && beat_q == KIND_QUAL) st_n = T_IDLE;
			default:   st_n = T_IDLE;
		endcase
	end

	assign ln_start = st_q == T_SQMUL;
	assign sq_start = st_q == T_SQSTART;
	assign cd_start = st_q == T_SQRT && !sq_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_ts_q <= '0;
			qmin_q    <= '0;
			qmax_q    <= '0;
			beat_q    <= '0;
		end else begin
			if (s_acc) begin
				if (is_clear) begin
					qmin_q <= '0;
					qmax_q <= '0;
				end else begin
					prev_ts_q <= s_tdata[143:112];
				end
			end
			if (st_q == T_LIN) begin
				if (qual_s2 < qmin_q) qmin_q <= qual_s2;
				if (qual_s2 > qmax_q) qmax_q <= qual_s2;
			end
			if (st_q == T_POST)
				beat_q <= '0;
			else if (st_q == T_OUT && m_tready)
				beat_q <= beat_q + 4'd1;
		end
	end

	// front end: products, sums, gravity and linear acceleration
	assign a12 = (AW'(xy_s1) + AW'(wz_s1)) <<< 1;
	assign a22 = AW'(ww_s1) + AW'(xx_s1) - AW'(yy_s1) - AW'(zz_s1);
	assign a31 = (AW'(wx_s1) + AW'(yz_s1)) <<< 1;
	assign a32 = (AW'(xz_s1) - AW'(wy_s1)) <<< 1;
	assign a33 = AW'(ww_s1) - AW'(xx_s1) - AW'(yy_s1) + AW'(zz_s1);

	assign mfull[0] = MAW'(35'sd1073741824) - (MAW'(yy_s1) <<< 1) - (MAW'(zz_s1) <<< 1);
	assign mfull[1] = (MAW'(xy_s1) <<< 1) - (MAW'(wz_s1) <<< 1);
	assign mfull[2] = (MAW'(xz_s1) <<< 1) + (MAW'(wy_s1) <<< 1);
	assign mfull[3] = (MAW'(xy_s1) <<< 1) + (MAW'(wz_s1) <<< 1);
	assign mfull[4] = MAW'(35'sd1073741824) - (MAW'(xx_s1) <<< 1) - (MAW'(zz_s1) <<< 1);
	assign mfull[5] = (MAW'(yz_s1) <<< 1) - (MAW'(wx_s1) <<< 1);
	assign mfull[6] = (MAW'(xz_s1) <<< 1) - (MAW'(wy_s1) <<< 1);
	assign mfull[7] = (MAW'(yz_s1) <<< 1) + (MAW'(wx_s1) <<< 1);
	assign mfull[8] = MAW'(35'sd1073741824) - (MAW'(xx_s1) <<< 1) - (MAW'(yy_s1) <<< 1);

	assign qsum = ((36'(ww_s1) + 36'(xx_s1) + 36'(yy_s1) + 36'(zz_s1)) <<< 1)
		- 36'sd2147483648;

	assign g31 = rnd14(MAW'(a31_s2));
	assign g32 = rnd14(MAW'(a32_s2));
	assign g33 = rnd14(MAW'(a33_s2));
	assign lraw[0] = (LINW'(ax_q) <<< 4) - LINW'(g32);
	assign lraw[1] = (LINW'(ay_q) <<< 4) - LINW'(g31);
	assign lraw[2] = (LINW'(az_q) <<< 4) - LINW'(g33);
	assign bandx   = LINW'({band_q, 4'b0});

	assign sclamp = (a32_s2 > AW'(34'sd1073741824)) ? 32'sd1073741824 :
		(a32_s2 < -AW'(34'sd1073741824)) ? -32'sd1073741824 : a32_s2[31:0];

	always_ff @(posedge clk) begin
		if (s_acc) begin
			w_q  <= s_tdata[15:0];
			x_q  <= s_tdata[31:16];
			y_q  <= s_tdata[47:32];
			z_q  <= s_tdata[63:48];
			ax_q <= s_tdata[79:64];
			ay_q <= s_tdata[95:80];
			az_q <= s_tdata[111:96];
			dt_q <= s_tdata[143:112] - prev_ts_q;
		end
		if (st_q == T_PROD) begin
			ww_s1 <= w_q * w_q;
			xx_s1 <= x_q * x_q;
			yy_s1 <= y_q * y_q;
			zz_s1 <= z_q * z_q;
			wx_s1 <= w_q * x_q;
			wy_s1 <= w_q * y_q;
			wz_s1 <= w_q * z_q;
			xy_s1 <= x_q * y_q;
			xz_s1 <= x_q * z_q;
			yz_s1 <= y_q * z_q;
		end
		if (st_q == T_SUMS) begin
			a12_s2  <= a12;
			a22_s2  <= a22;
			a31_s2  <= a31;
			a32_s2  <= a32;
			a33_s2  <= a33;
			qual_s2 <= sat32(SATW'(qsum));
			for (int i = 0; i < 9; i++)
				m_s2[i] <= rnd14(mfull[i]);
		end
		if (st_q == T_LIN) begin
			g31_s3  <= g31;
			g32_s3  <= g32;
			g33_s3  <= g33;
			sin_s3  <= sclamp;
			mabs_s3 <= sclamp[31] ? RTW'(-sclamp) : RTW'(sclamp);
			for (int i = 0; i < 3; i++)
				lin_s3[i] <= (labs[i] < bandx) ? '0 : lraw[i];
		end
		if (st_q == T_SQMUL)
			msq_s4 <= mabs_s3 * mabs_s3;
		if (st_q == T_POST) begin
			roll_q  <= roll_n;
			pitch_q <= pitch_n;
			yaw_q   <= yaw4;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			labs[i] = lraw[i][LINW-1] ? LINW'(-lraw[i]) : LINW'(lraw[i]);
	end

	// square root for the pitch cosine
	qadr_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n_in   (SQW'(62'(ONE_Q60) - msq_s4)),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	// CORDIC lanes: roll, pitch, yaw
	assign cd_y[0] = CW'(a31_s2);
	assign cd_x[0] = CW'(a33_s2);
	assign cd_y[1] = CW'(sin_s3);
	assign cd_x[1] = CW'({1'b0, sq_root});
	assign cd_y[2] = CW'(a12_s2);
	assign cd_x[2] = CW'(a22_s2);

	for (genvar g = 0; g < 3; g++) begin : g_cordic
		qadr_cordic u_cordic (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (cd_start),
			.y_in   (cd_y[g]),
			.x_in   (cd_x[g]),
			.busy   (cd_busy[g]),
			.z_out  (cd_z[g])
		);
	end

	// integrator lanes: x, y, z
	for (genvar g = 0; g < 3; g++) begin : g_intg
		qadr_intg u_intg (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (ln_start),
			.clear  (s_acc && is_clear),
			.lin    (lin_s3[g]),
			.dt     (dt_q),
			.stat   (ln_stat[g])
		);
	end

	assign lanes_busy = ln_stat[0].busy || ln_stat[1].busy || ln_stat[2].busy;

	// Q29 -> Q3.13 and yaw wrap into [0, 2pi)
	always_comb begin
		roll_n  = -ANGW'((36'(cd_z[0]) + 36'sd32768) >>> 16);
		pitch_n = ANGW'((36'(cd_z[1]) + 36'sd32768) >>> 16);
		yaw0    = -ANGW'((36'(cd_z[2]) + 36'sd32768) >>> 16) + ANGW'(decl_q);
		yaw1    = (yaw0 < 0) ? yaw0 + TWO_PI_Q13 : yaw0;
		yaw2    = (yaw1 < 0) ? yaw1 + TWO_PI_Q13 : yaw1;
		yaw3    = (yaw2 >= TWO_PI_Q13) ? yaw2 - TWO_PI_Q13 : yaw2;
		yaw4    = (yaw3 >= TWO_PI_Q13) ? yaw3 - TWO_PI_Q13 : yaw3;
	end

	// result merge
	always_comb begin
		case (beat_q)
			KIND_ANGLES: begin
				va = 32'(roll_q); vb = 32'(pitch_q); vc = 32'(yaw_q);
			end
			KIND_GRAVITY: begin
				va = -32'(g32_s3); vb = 32'(g31_s3); vc = 32'(g33_s3);
			end
			KIND_LIN: begin
				va = 32'(lin_s3[0]); vb = 32'(lin_s3[1]); vc = 32'(lin_s3[2]);
			end
			KIND_DISP: begin
				va = sat32(SATW'(ln_stat[0].disp));
				vb = sat32(SATW'(ln_stat[1].disp));
				vc = sat32(SATW'(ln_stat[2].disp));
			end
			KIND_VEL: begin
				va = sat32(SATW'(ln_stat[0].vel));
				vb = sat32(SATW'(ln_stat[1].vel));
				vc = sat32(SATW'(ln_stat[2].vel));
			end
			KIND_POS: begin
				va = sat32(SATW'(ln_stat[0].pos));
				vb = sat32(SATW'(ln_stat[1].pos));
				vc = sat32(SATW'(ln_stat[2].pos));
			end
			KIND_ROW0: begin
				va = 32'(m_s2[0]); vb = 32'(m_s2[1]); vc = 32'(m_s2[2]);
			end
			KIND_ROW1: begin
				va = 32'(m_s2[3]); vb = 32'(m_s2[4]); vc = 32'(m_s2[5]);
			end
			KIND_ROW2: begin
				va = 32'(m_s2[6]); vb = 32'(m_s2[7]); vc = 32'(m_s2[8]);
			end
			KIND_QUAL: begin
				va = qual_s2; vb = qmin_q; vc = qmax_q;
			end
			default: begin
				va = '0; vb = '0; vc = '0;
			end
		endcase
	end

	assign m_tvalid = st_q == T_OUT;
	assign m_tdata  = {vc, vb, va};
	assign m_tuser  = beat_q;
	assign m_tlast  = beat_q == KIND_QUAL;

endmodule

### hw/rtl/qadr_cordic.sv
// qadr_cordic: one vectoring CORDIC lane, atan2(y, x) in Q29, one step per cycle.
// Depends on qadr_pkg.
module qadr_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [qadr_pkg::CW-1:0] y_in,
	input  logic signed [qadr_pkg::CW-1:0] x_in,
	output logic                          busy,
	output logic signed [qadr_pkg::ZW-1:0] z_out
);
	import qadr_pkg::*;

	logic signed [CW-1:0] x_q, y_q, xsh, ysh;
	logic signed [ZW-1:0] z_q, at;
	logic [CIW-1:0]       cnt_q;
	logic                 busy_q;

	assign xsh = x_q >>> cnt_q;
	assign ysh = y_q >>> cnt_q;
	assign at  = ATAN_Q29[5'(cnt_q)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			cnt_q  <= '0;
			busy_q <= !(x_in == '0 && y_in == '0);
		end else if (busy_q) begin
			cnt_q <= cnt_q + CIW'(1);
			if (cnt_q == CIW'(CORDIC_STEPS - 1))
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			if (x_in < 0) begin
				z_q <= (y_in >= 0) ? PI_Q29 : -PI_Q29;
				x_q <= -x_in;
				y_q <= -y_in;
			end else begin
				z_q <= '0;
				x_q <= x_in;
				y_q <= y_in;
			end
		end else if (busy_q) begin
			if (y_q >= 0) begin
				x_q <= x_q + ysh;
				y_q <= y_q - xsh;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ysh;
				y_q <= y_q + xsh;
				z_q <= z_q - at;
			end
		end
	end

	assign busy  = busy_q;
	assign z_out = z_q;

endmodule

### hw/rtl/qadr_isqrt.sv
// qadr_isqrt: bit-pair integer square root, one root bit per cycle.
// Depends on qadr_pkg.
module qadr_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [qadr_pkg::SQW-1:0]   n_in,
	output logic                       busy,
	output logic [qadr_pkg::RTW-1:0]   root
);
	import qadr_pkg::*;

	logic [SQW-1:0] n_q, res_q, bit_q, trial;
	logic           busy_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			busy_q <= 1'b0;
		else if (start)
			busy_q <= 1'b1;
		else if (busy_q && bit_q[0])
			busy_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n_in;
			res_q <= '0;
			bit_q <= ONE_Q60;
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign busy = busy_q;
	assign root = res_q[RTW-1:0];

endmodule

### hw/rtl/qadr_intg.sv
// qadr_intg: one axis of the dead-reckoning integrator with a shift-add
// multiplier and a divide by 10^6 by reciprocal multiplication, 12 bits at a time.
// Depends on qadr_pkg.
module qadr_intg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             clear,
	input  logic signed [qadr_pkg::LINW-1:0] lin,
	input  logic [qadr_pkg::TSW-1:0]         dt,
	output qadr_pkg::intg_stat_t             stat
);
	import qadr_pkg::*;

	lane_st_t st_q, st_n;

	logic                          op2_q, neg_q, last_mul, last_div;
	logic [DCW-1:0]                cnt_q;
	logic [OPW-1:0]                mag_q, mag_n;
	logic [TSW-1:0]                dsh_q;
	logic [DIVW-1:0]               acc_q, acc_div;
	logic [19:0]                   rem_q, rem_n;
	logic [31:0]                   dvd;
	logic [64:0]                   prod_q;
	logic [DCH-1:0]                qd;
	logic signed [DVW-1:0]         res_mag, res, half, rbit, dv_q;
	logic signed [SATW-1:0]        a2;
	logic signed [OPW-1:0]         op;
	logic                          neg_n;
	logic signed [STATE_WIDTH-1:0] vel_q, pos_q, disp_q, disp_n;

	assign last_mul = cnt_q == DCW'(TSW - 1);
	assign last_div = cnt_q == DCW'(2 * NCH - 1);

	// even step: reciprocal product, odd step: quotient digit and remainder
	assign dvd     = {rem_q, acc_q[DIVW-1 -: DCH]};
	assign qd      = DCH'(prod_q >> RCPSH);
	assign rem_n   = 20'(dvd - 32'(qd) * 32'(USEC));
	assign acc_div = {acc_q[DIVW-DCH-1:0], qd};
	assign res_mag = signed'({1'b0, acc_div[QW-1:0]});
	assign res     = neg_q ? -res_mag : res_mag;
	assign rbit    = signed'({{(DVW-1){1'b0}}, res[DVW-1]});
	assign half    = (res + rbit) >>> 1;
	assign a2      = SATW'(vel_q) + SATW'(half);
	assign op      = a2[OPW-1:0];
	assign neg_n   = op[OPW-1];
	assign mag_n   = neg_n ? OPW'(-op) : OPW'(op);
	assign disp_n  = sat_state(SATW'(res));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= LN_IDLE;
		else
			st_q <= st_n;
	end

	always_comb begin
		st_n = st_q;
		case (st_q)
			LN_IDLE: if (start) st_n = LN_MUL;
			LN_MUL:  if (last_mul) st_n = LN_DIV;
			LN_DIV:  if (last_div) st_n = op2_q ? LN_IDLE : LN_MUL;
			default: st_n = LN_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			op2_q <= 1'b0;
			vel_q <= '0;
			pos_q <= '0;
		end else begin
			case (st_q)
				LN_IDLE: begin
					cnt_q <= '0;
					op2_q <= 1'b0;
					if (clear) begin
						vel_q <= '0;
						pos_q <= '0;
					end
				end
				LN_MUL: cnt_q <= last_mul ? '0 : cnt_q + DCW'(1);
				LN_DIV: begin
					cnt_q <= last_div ? '0 : cnt_q + DCW'(1);
					if (last_div) begin
						op2_q <= 1'b1;
						if (op2_q) begin
							vel_q <= sat_state(SATW'(vel_q) + SATW'(dv_q));
							pos_q <= sat_state(SATW'(pos_q) + SATW'(disp_n));
						end
					end
				end
				default: cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			LN_IDLE: begin
				if (start) begin
					neg_q <= lin < 0;
					mag_q <= (lin < 0) ? OPW'(-OPW'(lin)) : OPW'(lin);
					dsh_q <= dt;
					acc_q <= '0;
				end
			end
			LN_MUL: begin
				acc_q <= (acc_q << 1) + (dsh_q[TSW-1] ? DIVW'(mag_q) : '0);
				dsh_q <= dsh_q << 1;
				rem_q <= '0;
			end
			LN_DIV: begin
				if (!cnt_q[0]) begin
					prod_q <= dvd * RCP;
				end else if (!last_div) begin
					acc_q <= acc_div;
					rem_q <= rem_n;
				end else if (!op2_q) begin
					dv_q  <= res;
					neg_q <= neg_n;
					mag_q <= mag_n;
					dsh_q <= dt;
					acc_q <= '0;
				end else begin
					disp_q <= disp_n;
				end
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign stat.busy = st_q != LN_IDLE;
	assign stat.disp = disp_q;
	assign stat.vel  = vel_q;
	assign stat.pos  = pos_q;

endmodule
